>>> rtl/core/u2u_pkg.sv
// shared types and constants of the utf-8 to utf-16 transcoder
`timescale 1ns / 1ps
package u2u_pkg;

   localparam int CapWidth   = 21;
   localparam int UnitWidth  = 16;
   localparam int CodeWidth  = 21;
   localparam int CountWidth = 20;

   localparam logic [CapWidth-1:0] CAP_RESET = 21'd65536;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // terminator stop reasons
   localparam logic [1:0] STOP_ENDED   = 2'd0;
   localparam logic [1:0] STOP_INVALID = 2'd1;
   localparam logic [1:0] STOP_FULL    = 2'd2;

   localparam logic [UnitWidth-1:0] HI_SURR  = 16'hD800;
   localparam logic [UnitWidth-1:0] LO_SURR  = 16'hDC00;
   localparam logic [CodeWidth-1:0] MAX_CODE = 21'h10FFFF;
   localparam logic [CodeWidth-1:0] PLANE1   = 21'h010000;

   // one queue entry: the results caused by one input beat
   typedef struct packed {
      logic [1:0]            n_units;
      logic [UnitWidth-1:0]  unit0;
      logic [UnitWidth-1:0]  unit1;
      logic                  has_term;
      logic [1:0]            reason;
      logic [CapWidth-1:0]   count;
   } u2u_entry_type;

   // smallest legal code point for a sequence with the given trail count
   function automatic logic [CodeWidth-1:0] min_code(input logic [1:0] seq);
      logic [CodeWidth-1:0] m;
      case (seq)
         2'd1: begin
            m = 21'h000080;
         end
         2'd2: begin
            m = 21'h000800;
         end
         default: begin
            m = 21'h010000;
         end
      endcase
      return m;
   endfunction

endpackage

>>> rtl/core/u2u_if.sv
// handshake channels of the transcoder: byte request, unit response, capacity write
`timescale 1ns / 1ps
interface u2u_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       has_byte;
   logic       end_of_string;
   modport source (output valid, in_byte, has_byte, end_of_string, input ready);
   modport sink   (input valid, in_byte, has_byte, end_of_string, output ready);
endinterface

interface u2u_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_unit;
   logic        is_terminator;
   logic [1:0]  stop_reason;
   logic [20:0] byte_count;
   logic        run_last;
   modport source (output valid, out_unit, is_terminator, stop_reason, byte_count,
                   run_last, input ready);
   modport sink   (input valid, out_unit, is_terminator, stop_reason, byte_count,
                   run_last, output ready);
endinterface

interface u2u_csr_if;
   logic        valid;
   logic        ready;
   logic [20:0] out_capacity;
   modport source (output valid, out_capacity, input ready);
   modport sink   (input valid, out_capacity, output ready);
endinterface

>>> rtl/core/u2u_front.sv
// front end: accepts bytes, decodes utf-8 and builds at most one queue entry per beat
`timescale 1ns / 1ps
module u2u_front (
   input  logic                  clock,
   input  logic                  reset,
   u2u_req_if.sink               req,
   u2u_csr_if.sink               csr,
   input  logic                  q_full,
   output logic                  push,
   output u2u_pkg::u2u_entry_type entry
);

   logic [u2u_pkg::CodeWidth-1:0]  code_ff, code_in;
   logic [1:0]                     trail_ff, trail_in;
   logic [1:0]                     seq_ff, seq_in;
   logic [u2u_pkg::CountWidth-1:0] units_ff, units_in;
   logic                           halted_ff, halted_in;
   logic [u2u_pkg::CapWidth-1:0]   cap_ff;

   logic                           accept;
   logic                           emit;
   logic [u2u_pkg::CodeWidth-1:0]  chr;
   logic [u2u_pkg::CodeWidth-1:0]  shifted;
   logic [1:0]                     trail_dec;
   logic                           stop;
   logic [1:0]                     stop_why;
   logic                           wide;
   logic [u2u_pkg::CapWidth:0]     need;
   logic [u2u_pkg::CapWidth-1:0]   cap_eff;
   logic [u2u_pkg::CapWidth-1:0]   limit;
   logic [u2u_pkg::CodeWidth-1:0]  offs;
   logic [u2u_pkg::CapWidth-1:0]   total_bytes;

   assign accept  = req.valid & req.ready;
   assign req.ready = ~q_full;
   assign csr.ready = 1'b1;

   assign shifted   = {code_ff[14:0], req.in_byte[5:0]};
   assign trail_dec = trail_ff - 2'd1;
   assign wide      = chr > 21'h00FFFF;
   assign need      = {1'b0, units_ff, 1'b0} + (wide ? 22'd4 : 22'd2);
   assign cap_eff   = (cap_ff < 21'd2) ? 21'd2 : cap_ff;
   assign limit     = cap_eff - 21'd2;
   assign offs      = chr - u2u_pkg::PLANE1;

   always_comb begin
      code_in     = code_ff;
      trail_in    = trail_ff;
      seq_in      = seq_ff;
      units_in    = units_ff;
      halted_in   = halted_ff;
      emit        = 1'b0;
      chr         = '0;
      stop        = 1'b0;
      stop_why    = u2u_pkg::STOP_INVALID;
      entry       = '0;
      total_bytes = '0;

      // byte decode
      if (req.has_byte && !halted_ff) begin
         if (trail_ff == 2'd0) begin
            if (req.in_byte <= 8'h7F) begin
               emit = 1'b1;
               chr  = {13'd0, req.in_byte};
            end else if (req.in_byte <= 8'hC1 || req.in_byte > 8'hF4) begin
               stop = 1'b1;
            end else if (req.in_byte <= 8'hDF) begin
               code_in  = {16'd0, req.in_byte[4:0]};
               trail_in = 2'd1;
               seq_in   = 2'd1;
            end else if (req.in_byte <= 8'hEF) begin
               code_in  = {17'd0, req.in_byte[3:0]};
               trail_in = 2'd2;
               seq_in   = 2'd2;
            end else begin
               code_in  = {18'd0, req.in_byte[2:0]};
               trail_in = 2'd3;
               seq_in   = 2'd3;
            end
         end else if (req.in_byte[7:6] != 2'b10) begin
            stop = 1'b1;
         end else begin
            code_in  = shifted;
            trail_in = trail_dec;
            if (trail_dec == 2'd0) begin
               seq_in = 2'd0;
               // overlong or beyond the last plane
               if (shifted < u2u_pkg::min_code(seq_ff) || shifted > u2u_pkg::MAX_CODE) begin
                  stop = 1'b1;
               end else begin
                  emit = 1'b1;
                  chr  = shifted;
               end
            end
         end
      end

      // capacity check and unit build
      if (emit) begin
         if (need > {1'b0, limit}) begin
            stop     = 1'b1;
            stop_why = u2u_pkg::STOP_FULL;
         end else if (!wide) begin
            entry.n_units = 2'd1;
            entry.unit0   = chr[15:0];
            units_in      = units_ff + 20'd1;
         end else begin
            entry.n_units = 2'd2;
            entry.unit0   = u2u_pkg::HI_SURR | {6'd0, offs[19:10]};
            entry.unit1   = u2u_pkg::LO_SURR | {6'd0, offs[9:0]};
            units_in      = units_ff + 20'd2;
         end
      end

      if (stop) begin
         halted_in      = 1'b1;
         entry.has_term = 1'b1;
         entry.reason   = stop_why;
      end

      // bytes written including the terminator, counted before any rearm
      total_bytes = {units_in, 1'b0} + 21'd2;

      // end marker closes the string and rearms
      if (req.end_of_string) begin
         if (!halted_in) begin
            entry.has_term = 1'b1;
            entry.reason   = (trail_in != 2'd0) ? u2u_pkg::STOP_INVALID
                                                : u2u_pkg::STOP_ENDED;
         end
         code_in   = '0;
         trail_in  = 2'd0;
         seq_in    = 2'd0;
         units_in  = '0;
         halted_in = 1'b0;
      end

      entry.count = entry.has_term ? total_bytes : '0;
   end

   assign push = accept && (entry.n_units != 2'd0 || entry.has_term);

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff   <= '0;
         trail_ff  <= 2'd0;
         seq_ff    <= 2'd0;
         units_ff  <= '0;
         halted_ff <= 1'b0;
         cap_ff    <= u2u_pkg::CAP_RESET;
      end else begin
         if (accept) begin
            code_ff   <= code_in;
            trail_ff  <= trail_in;
            seq_ff    <= seq_in;
            units_ff  <= units_in;
            halted_ff <= halted_in;
         end
         if (csr.valid) begin
            cap_ff <= csr.out_capacity;
         end
      end
   end

endmodule

>>> rtl/core/u2u_queue.sv
// short entry queue between decode front and result back end
`timescale 1ns / 1ps
module u2u_queue #(
   parameter int Depth = u2u_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  u2u_pkg::u2u_entry_type wr_entry,
   input  logic                   pop,
   output u2u_pkg::u2u_entry_type head,
   output logic                   not_empty,
   output logic                   full
);

   localparam int PtrWidth = $clog2(Depth);
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   u2u_pkg::u2u_entry_type slot_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0] cnt_ff;
   logic                do_push, do_pop;

   assign full      = cnt_ff == FullCnt;
   assign not_empty = cnt_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

>>> rtl/core/u2u_back.sv
// back end: unrolls each queue entry into response beats, one per cycle while ready
`timescale 1ns / 1ps
module u2u_back (
   input  logic                   clock,
   input  logic                   reset,
   input  u2u_pkg::u2u_entry_type head,
   input  logic                   not_empty,
   output logic                   pop,
   u2u_rsp_if.source              rsp
);

   logic [1:0]  idx_ff;
   logic        valid_ff;
   logic [15:0] unit_ff;
   logic        term_ff;
   logic [1:0]  reason_ff;
   logic [20:0] count_ff;
   logic        last_ff;

   logic [1:0]  total;
   logic        is_last;
   logic        is_unit;
   logic        load;

   assign total   = head.n_units + {1'b0, head.has_term};
   assign is_last = (idx_ff + 2'd1) == total;
   assign is_unit = idx_ff < head.n_units;
   assign load    = not_empty && (!valid_ff || rsp.ready);
   assign pop     = load && is_last;

   assign rsp.valid         = valid_ff;
   assign rsp.out_unit      = unit_ff;
   assign rsp.is_terminator = term_ff;
   assign rsp.stop_reason   = reason_ff;
   assign rsp.byte_count    = count_ff;
   assign rsp.run_last      = last_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         unit_ff   <= is_unit ? ((idx_ff == 2'd0) ? head.unit0 : head.unit1) : '0;
         term_ff   <= !is_unit;
         reason_ff <= is_unit ? u2u_pkg::STOP_ENDED : head.reason;
         count_ff  <= is_unit ? '0 : head.count;
         last_ff   <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= is_last ? 2'd0 : idx_ff + 2'd1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule

>>> rtl/core/utf8_to_utf16_transcoder.sv
// top level of the utf-8 to utf-16 transcoder
// path: an accepted request beat is written into the queue, then loaded into the registered
//   response stage that drives the first response beat
// throughput: one request beat per cycle when the queue has room, one response beat per
//   cycle if ready; a surrogate pair plus terminator is three beats, absorbed by the queue
// reset: synchronous, clears decode state and queue, capacity returns to 65536 bytes
`timescale 1ns / 1ps
module utf8_to_utf16_transcoder #(
   parameter int QueueDepth = u2u_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   u2u_req_if.sink   req_chan,
   u2u_rsp_if.source rsp_chan,
   u2u_csr_if.sink   csr_chan
);

   // entry handed from decode to the result stage
   u2u_pkg::u2u_entry_type wr_entry;
   u2u_pkg::u2u_entry_type head;
   logic                   push;
   logic                   pop;
   logic                   not_empty;
   logic                   q_full;

   // front: takes a request beat each cycle the queue has room, decodes the byte,
   // checks capacity and pushes the units and any terminator of that beat
   u2u_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .csr    (csr_chan),
      .q_full (q_full),
      .push   (push),
      .entry  (wr_entry)
   );

   // queue decouples byte intake from unit output
   u2u_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_entry  (wr_entry),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (q_full)
   );

   // back: registered response stage, pops an entry after its last beat
   u2u_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

endmodule
